>>> rtl/lxc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lxc_pkg
// Shared types and constants of the lux compensation pipeline.
// ----------------------------------------------------------------------------
package lxc_pkg;

  typedef enum logic [1:0] {
    REG_MEAS_TIME  = 2'd0,
    REG_TEMP       = 2'd1,
    REG_WAVELENGTH = 2'd2,
    REG_RES_MODE   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_2,
    DIV_7,
    DIV_35,
    DIV_3
  } div_e;

  localparam int unsigned CFG_W    = 10;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned MT_W     = 8;
  localparam int unsigned TEMP_W   = 8;
  localparam int unsigned WL_W     = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned TF_W     = 14;
  localparam int unsigned SENS_W   = 14;
  localparam int unsigned LUX_W    = 31;

  localparam int unsigned RAW_DIV  = 3;
  localparam int unsigned COMP_DIV = 10000;

  localparam logic [MT_W-1:0]   MT_RESET   = 8'd69;
  localparam logic [TEMP_W-1:0] TEMP_RESET = 8'd20;
  localparam logic [WL_W-1:0]   WL_RESET   = 10'd580;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALF_RES = 2'd2;

  localparam logic [MT_W-1:0] MT_MIN = 8'd31;
  localparam logic [MT_W-1:0] MT_MAX = 8'd254;
  localparam logic [WL_W-1:0] WL_MIN = 10'd400;
  localparam logic [WL_W-1:0] WL_MAX = 10'd715;

  localparam int unsigned SENS_K = 20;
  localparam logic [19:0] RECIP_2  = 20'((1 << SENS_K) / 2);
  localparam logic [19:0] RECIP_7  = 20'((1 << SENS_K) / 7);
  localparam logic [19:0] RECIP_35 = 20'((1 << SENS_K) / 35);
  localparam logic [19:0] RECIP_3  = 20'((1 << SENS_K) / 3);

  function automatic logic [11:0] div_value(div_e sel);
    logic [11:0] v;
    case (sel)
      DIV_2:   v = 12'd2;
      DIV_7:   v = 12'd7;
      DIV_35:  v = 12'd35;
      DIV_3:   v = 12'd3;
      default: v = 12'd2;
    endcase
    return v;
  endfunction

  function automatic logic [19:0] div_recip(div_e sel);
    logic [19:0] r;
    case (sel)
      DIV_2:   r = RECIP_2;
      DIV_7:   r = RECIP_7;
      DIV_35:  r = RECIP_35;
      DIV_3:   r = RECIP_3;
      default: r = RECIP_2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lxc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lxc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband,
// and a five-stage divider by a constant through reciprocal multiplication.
// ----------------------------------------------------------------------------
module lxc_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned PW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [PW-1:0]      pay_o
);

  logic          vld_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] acc_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [PW-1:0] pay_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic          cur_vld;
    logic [DW-1:0] cur_rem;
    logic [NW-1:0] cur_acc;
    logic [DW-1:0] cur_den;
    logic [PW-1:0] cur_pay;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] rem_d;
    logic [NW-1:0] acc_d;

    if (i == 0) begin : g_first
      assign cur_vld = valid_i;
      assign cur_rem = '0;
      assign cur_acc = num_i;
      assign cur_den = den_i;
      assign cur_pay = pay_i;
    end else begin : g_next
      assign cur_vld = vld_q[i-1];
      assign cur_rem = rem_q[i-1];
      assign cur_acc = acc_q[i-1];
      assign cur_den = den_q[i-1];
      assign cur_pay = pay_q[i-1];
    end

    always_comb begin
      trial = {cur_rem, cur_acc[NW-1]};
      diff  = trial - {1'b0, cur_den};
      take  = (trial >= {1'b0, cur_den});
      rem_d = take ? diff[DW-1:0] : trial[DW-1:0];
      acc_d = {cur_acc[NW-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        acc_q[i] <= acc_d;
        den_q[i] <= cur_den;
        pay_q[i] <= cur_pay;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = acc_q[NW-1];
  assign pay_o   = pay_q[NW-1];

endmodule

// The estimate is the numerator times floor(2^NW / D), shifted down by NW.
// It is at most one below the true quotient, and a final compare and add
// settles it.
module lxc_cdiv #(
  parameter int unsigned NW = 24,
  parameter int unsigned D  = 3,
  parameter int unsigned PW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [PW-1:0]      pay_o
);

  localparam int unsigned RW  = NW - $clog2(D) + 1;
  localparam int unsigned HN  = NW / 2;
  localparam int unsigned NHW = NW - HN;
  localparam int unsigned HR  = RW / 2;
  localparam int unsigned RHW = RW - HR;
  localparam int unsigned LLW = HN + HR;
  localparam int unsigned LHW = HN + RHW;
  localparam int unsigned HLW = NHW + HR;
  localparam int unsigned HHW = NHW + RHW;
  localparam int unsigned PRW = NW + RW;

  localparam logic [63:0]   RECIP_FULL = (64'd1 << NW) / 64'(D);
  localparam logic [RW-1:0] RECIP      = RECIP_FULL[RW-1:0];
  localparam logic [NW-1:0] DIVISOR    = NW'(D);

  logic            v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [LLW-1:0]  ll_q;
  logic [LHW-1:0]  lh_q;
  logic [HLW-1:0]  hl_q;
  logic [HHW-1:0]  hh_q;
  logic [PRW-1:0]  sa_q;
  logic [PRW-1:0]  sb_q;
  logic [PRW-1:0]  prod;
  logic [RW-1:0]   est3_q, est4_q;
  logic [NW-1:0]   back4_q;
  logic [NW-1:0]   rem;
  logic [NW-1:0]   quo5_q;
  logic [NW-1:0]   n1_q, n2_q, n3_q, n4_q;
  logic [PW-1:0]   p1_q, p2_q, p3_q, p4_q, p5_q;

  always_comb begin
    prod = sa_q + sb_q;
    rem  = n4_q - back4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q    <= LLW'(num_i[HN-1:0]) * LLW'(RECIP[HR-1:0]);
      lh_q    <= LHW'(num_i[HN-1:0]) * LHW'(RECIP[RW-1:HR]);
      hl_q    <= HLW'(num_i[NW-1:HN]) * HLW'(RECIP[HR-1:0]);
      hh_q    <= HHW'(num_i[NW-1:HN]) * HHW'(RECIP[RW-1:HR]);
      n1_q    <= num_i;
      p1_q    <= pay_i;
      sa_q    <= {hh_q, ll_q};
      sb_q    <= (PRW'(hl_q) << HN) + (PRW'(lh_q) << HR);
      n2_q    <= n1_q;
      p2_q    <= p1_q;
      est3_q  <= prod[PRW-1:NW];
      n3_q    <= n2_q;
      p3_q    <= p2_q;
      back4_q <= NW'(est3_q) * DIVISOR;
      est4_q  <= est3_q;
      n4_q    <= n3_q;
      p4_q    <= p3_q;
      quo5_q  <= NW'(est4_q) + NW'(rem >= DIVISOR);
      p5_q    <= p4_q;
    end
  end

  assign valid_o = v5_q;
  assign quo_o   = quo5_q;
  assign pay_o   = p5_q;

endmodule
`default_nettype wire

>>> rtl/lxc_sens.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lxc_sens
// Three-stage piecewise-linear relative spectral sensitivity.
// ----------------------------------------------------------------------------
module lxc_sens #(
  parameter int unsigned PW = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [lxc_pkg::WL_W-1:0]     wl_i,
  input  wire logic [PW-1:0]                pay_i,
  output logic                              valid_o,
  output logic [lxc_pkg::SENS_W-1:0]        sens_o,
  output logic [PW-1:0]                     pay_o
);
  import lxc_pkg::*;

  logic [6:0]        d;
  logic [10:0]       c;
  div_e              dsel_d;
  logic [SENS_W-1:0] base_d;
  logic              neg_d;
  logic [17:0]       n_full;

  logic              a_vld_q, b_vld_q, c_vld_q;
  logic [16:0]       a_n_q, b_n_q;
  div_e              a_dsel_q, b_dsel_q;
  logic [SENS_W-1:0] a_base_q, b_base_q;
  logic              a_neg_q, b_neg_q;
  logic [PW-1:0]     a_pay_q, b_pay_q, c_pay_q;
  logic [16:0]       b_est_q;
  logic [SENS_W-1:0] c_sens_q;

  logic [36:0]       prod_b;
  logic [11:0]       dv;
  logic [28:0]       back;
  logic [16:0]       r;
  logic [16:0]       q;
  logic signed [18:0] s_val;
  logic [SENS_W-1:0] sens_d;

  always_comb begin
    if (wl_i < 10'd440) begin
      d = 7'(wl_i - 10'd400); c = 11'd45;   dsel_d = DIV_2;  base_d = 14'd100;   neg_d = 1'b0;
    end else if (wl_i < 10'd510) begin
      d = 7'(wl_i - 10'd440); c = 11'd800;  dsel_d = DIV_7;  base_d = 14'd1000;  neg_d = 1'b0;
    end else if (wl_i < 10'd545) begin
      d = 7'(wl_i - 10'd510); c = 11'd1000; dsel_d = DIV_35; base_d = 14'd9000;  neg_d = 1'b1;
    end else if (wl_i < 10'd580) begin
      d = 7'(wl_i - 10'd545); c = 11'd2000; dsel_d = DIV_35; base_d = 14'd8000;  neg_d = 1'b0;
    end else if (wl_i < 10'd700) begin
      d = 7'(wl_i - 10'd580); c = 11'd155;  dsel_d = DIV_2;  base_d = 14'd10000; neg_d = 1'b1;
    end else if (wl_i < 10'd715) begin
      d = 7'(wl_i - 10'd700); c = 11'd140;  dsel_d = DIV_3;  base_d = 14'd700;   neg_d = 1'b1;
    end else begin
      d = 7'd0;               c = 11'd0;    dsel_d = DIV_2;  base_d = 14'd100;   neg_d = 1'b0;
    end
    n_full = 18'(d) * 18'(c);
  end

  always_comb begin
    prod_b = 37'(a_n_q) * 37'(div_recip(a_dsel_q));
  end

  always_comb begin
    dv    = div_value(b_dsel_q);
    back  = 29'(b_est_q) * 29'(dv);
    r     = b_n_q - back[16:0];
    q     = b_est_q + 17'((r >= 17'(dv)) ? 1 : 0);
    s_val = b_neg_q ? (19'(b_base_q) - 19'(q)) : (19'(b_base_q) + 19'(q));
    sens_d = (s_val < 19'sd1) ? 14'd1 : s_val[SENS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_n_q    <= n_full[16:0];
      a_dsel_q <= dsel_d;
      a_base_q <= base_d;
      a_neg_q  <= neg_d;
      a_pay_q  <= pay_i;
      b_est_q  <= prod_b[36:SENS_K];
      b_n_q    <= a_n_q;
      b_dsel_q <= a_dsel_q;
      b_base_q <= a_base_q;
      b_neg_q  <= a_neg_q;
      b_pay_q  <= a_pay_q;
      c_sens_q <= sens_d;
      c_pay_q  <= b_pay_q;
    end
  end

  assign valid_o = c_vld_q;
  assign sens_o  = c_sens_q;
  assign pay_o   = c_pay_q;

endmodule
`default_nettype wire

>>> rtl/light_sensor_lux_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// light_sensor_lux_compensation
// Raw light count to compensated illuminance in hundredths of a lux.
// ----------------------------------------------------------------------------
// One request enters per clock unless the output stalls, and its result
// passes through the two long-division pipelines, each of which resolves
// one quotient bit per stage (27 stages for the wavelength factor and 29 for
// the measurement time), the three five-stage divisions by a constant, the
// three-stage sensitivity, and the input, multiply and output registers. A
// stall on the output holds the whole pipeline in place. Configuration takes
// effect for requests accepted after the write.
module light_sensor_lux_compensation (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [lxc_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // raw_count[15:0]
  input  wire logic [15:0]                 s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // lux_hundredths[30:0], zero[31]
  output logic [31:0]                      m_axis_tdata,
  // saturated[0]
  output logic                             m_axis_tuser
);
  import lxc_pkg::*;

  localparam int unsigned P0_W = 1 + TF_W + MT_W + RAW_W;
  localparam int unsigned P1_W = 1 + TF_W + MT_W + 27;
  localparam int unsigned P2_W = 1 + TF_W + 27;
  localparam int unsigned P3_W = 1 + 27;

  logic en;

  logic [MT_W-1:0]   mt_q;
  logic [TEMP_W-1:0] temp_q;
  logic [WL_W-1:0]   wl_q;
  logic [MODE_W-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mt_q   <= MT_RESET;
      temp_q <= TEMP_RESET;
      wl_q   <= WL_RESET;
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MEAS_TIME:  mt_q   <= cfg_data_i[MT_W-1:0];
        REG_TEMP:       temp_q <= cfg_data_i[TEMP_W-1:0];
        REG_WAVELENGTH: wl_q   <= cfg_data_i[WL_W-1:0];
        REG_RES_MODE:   mode_q <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [MT_W-1:0]    mt_c;
  logic [WL_W-1:0]    wl_c;
  logic signed [15:0] tdiff;
  logic signed [15:0] tf_s;

  always_comb begin
    mt_c  = (mt_q < MT_MIN) ? MT_MIN : ((mt_q > MT_MAX) ? MT_MAX : mt_q);
    wl_c  = (wl_q < WL_MIN) ? WL_MIN : ((wl_q > WL_MAX) ? WL_MAX : wl_q);
    tdiff = 16'($signed(temp_q)) - 16'sd20;
    tf_s  = 16'sd10000 - tdiff * 16'sd5;
  end

  logic              v0_q;
  logic [RAW_W-1:0]  raw0_q;
  logic [MT_W-1:0]   mt0_q;
  logic [WL_W-1:0]   wl0_q;
  logic [TF_W-1:0]   tf0_q;
  logic              hv0_q;

  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw0_q <= s_axis_tdata[RAW_W-1:0];
      mt0_q  <= mt_c;
      wl0_q  <= wl_c;
      tf0_q  <= tf_s[TF_W-1:0];
      hv0_q  <= (mode_q == MODE_HALF_RES);
    end
  end

  logic              sv;
  logic [SENS_W-1:0] sens;
  logic [P0_W-1:0]   sp;

  lxc_sens #(.PW(P0_W)) u_sens (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .wl_i(wl0_q),
    .pay_i({hv0_q, tf0_q, mt0_q, raw0_q}),
    .valid_o(sv), .sens_o(sens), .pay_o(sp)
  );

  logic            wv;
  logic [26:0]     wf;
  logic [P0_W-1:0] wp;

  lxc_div #(.NW(27), .DW(SENS_W), .PW(P0_W)) u_div_wf (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv), .num_i(27'd100000000), .den_i(sens),
    .pay_i(sp), .valid_o(wv), .quo_o(wf), .pay_o(wp)
  );

  logic            v1_q;
  logic [23:0]     p1_q;
  logic [P1_W-1:0] pay1_q;

  logic            v2_q;
  logic [28:0]     p2_q;
  logic [P2_W-1:0] pay2_q;
  logic [MT_W-1:0] mt2_q;

  logic            v3_q;
  logic [37:0]     p3_q;
  logic [P3_W-1:0] pay3_q;

  logic            v4_q;
  logic [50:0]     p4_q;
  logic            hv4_q;

  logic            d3v;
  logic [23:0]     d3q;
  logic [P1_W-1:0] d3p;
  logic            dmv;
  logic [28:0]     dmq;
  logic [P2_W-1:0] dmp;
  logic            dtv;
  logic [37:0]     dtq;
  logic [P3_W-1:0] dtp;
  logic            dwv;
  logic [50:0]     dwq;
  logic            dwp;

  logic [30:0]     prod2;

  assign prod2 = 31'(d3q) * 31'd69;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= wv;
      v2_q <= d3v;
      v3_q <= dmv;
      v4_q <= dtv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= 24'(wp[RAW_W-1:0]) * 24'd250;
      pay1_q <= {wp[P0_W-1:RAW_W], wf};
      p2_q   <= prod2[28:0];
      pay2_q <= {d3p[P1_W-1:P1_W-1-TF_W], d3p[26:0]};
      mt2_q  <= d3p[27 + MT_W - 1:27];
      p3_q   <= 38'(dmq[23:0]) * 38'(dmp[P2_W-2:27]);
      pay3_q <= {dmp[P2_W-1], dmp[26:0]};
      p4_q   <= 51'(dtq[23:0]) * 51'(dtp[26:0]);
      hv4_q  <= dtp[P3_W-1];
    end
  end

  lxc_cdiv #(.NW(24), .D(RAW_DIV), .PW(P1_W)) u_div_3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .num_i(p1_q),
    .pay_i(pay1_q), .valid_o(d3v), .quo_o(d3q), .pay_o(d3p)
  );

  lxc_div #(.NW(29), .DW(MT_W), .PW(P2_W)) u_div_mt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .num_i(p2_q),
    .den_i(mt2_q),
    .pay_i(pay2_q), .valid_o(dmv), .quo_o(dmq), .pay_o(dmp)
  );

  lxc_cdiv #(.NW(38), .D(COMP_DIV), .PW(P3_W)) u_div_tf (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .num_i(p3_q),
    .pay_i(pay3_q), .valid_o(dtv), .quo_o(dtq), .pay_o(dtp)
  );

  lxc_cdiv #(.NW(51), .D(COMP_DIV), .PW(1)) u_div_wl (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .num_i(p4_q),
    .pay_i(hv4_q), .valid_o(dwv), .quo_o(dwq), .pay_o(dwp)
  );

  logic [50:0]      halved;
  logic             sat_d;
  logic             out_vld_q;
  logic [LUX_W-1:0] lux_q;
  logic             sat_q;

  always_comb begin
    halved = dwp ? (dwq >> 1) : dwq;
    sat_d  = |halved[50:LUX_W];
  end

  assign en = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dwv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lux_q <= sat_d ? {LUX_W{1'b1}} : halved[LUX_W-1:0];
      sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, lux_q};
  assign m_axis_tuser  = sat_q;

endmodule
`default_nettype wire
